// ===== hw/rtl/skt_pkg.sv =====
package skt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_MISSING = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [POS_W-1:0]        position;
    logic [COUNT_W-1:0]      entry_count;
    logic signed [KEY_W-1:0] first_key;
    logic signed [KEY_W-1:0] last_key;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

// ===== hw/rtl/skt_ctrl.sv =====
module skt_ctrl
  import skt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  // A new item may enter once the result register is empty or is being drained.
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/skt_datapath.sv =====
module skt_datapath
  import skt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  input  in_item_t  in_item_i,
  output out_item_t out_item_o
);

  in_item_t                item_q;
  logic signed [KEY_W-1:0] keys_q [CAPACITY];
  logic signed [KEY_W-1:0] keys_d [CAPACITY];
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        count_d;
  out_item_t               out_q;
  out_item_t               out_d;

  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] ins_stop;
  logic [CAPACITY-1:0] ins_hit;
  logic [CAPACITY-1:0] fnd_stop;
  logic [CAPACITY-1:0] fnd_hit;
  logic [CAPACITY-1:0] eq;
  logic [IDX_W-1:0]    ins_pos;
  logic [IDX_W-1:0]    fnd_pos;
  logic                found;
  logic                full;
  logic [CNT_W-1:0]    last_cnt;
  logic [IDX_W-1:0]    last_idx;
  logic [1:0]          status;
  logic [IDX_W-1:0]    pos;

  // Every cell compares its own entry with the key. Because the entries stay
  // sorted, the compare results form a thermometer whose edge is the slot.
  always_comb begin
    ins_pos = '0;
    fnd_pos = '0;
    found   = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i]    = CNT_W'(i) < count_q;
      eq[i]       = keys_q[i] == item_q.key;
      ins_stop[i] = !(valid[i] && (keys_q[i] <= item_q.key));
      fnd_stop[i] = !(valid[i] && (keys_q[i] < item_q.key));
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        ins_hit[i] = ins_stop[i];
        fnd_hit[i] = fnd_stop[i];
      end else begin
        ins_hit[i] = ins_stop[i] && !ins_stop[i-1];
        fnd_hit[i] = fnd_stop[i] && !fnd_stop[i-1];
      end
      if (ins_hit[i]) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
      if (fnd_hit[i]) begin
        fnd_pos = fnd_pos | IDX_W'(i);
      end
      found = found | (fnd_hit[i] && valid[i] && eq[i]);
    end
  end

  assign full = count_q >= CNT_W'(CAPACITY);

  always_comb begin
    keys_d  = keys_q;
    count_d = count_q;
    status  = STATUS_DONE;
    pos     = '0;
    case (item_q.mode)
      MODE_INSERT: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          pos     = ins_pos;
          count_d = count_q + 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (ins_hit[i]) begin
              keys_d[i] = item_q.key;
            end else if (ins_stop[i] && i > 0) begin
              keys_d[i] = keys_q[(i > 0) ? i - 1 : 0];
            end
          end
        end
      end
      MODE_FIND: begin
        if (!found) begin
          status = STATUS_MISSING;
        end else begin
          pos = fnd_pos;
        end
      end
      MODE_DELETE: begin
        if (!found) begin
          status = STATUS_MISSING;
        end else begin
          pos     = fnd_pos;
          count_d = count_q - 1'b1;
          // Entries from the removed one upward move down by one.
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (fnd_stop[i]) begin
              keys_d[i] = keys_q[i+1];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign last_cnt = count_d - 1'b1;
  assign last_idx = last_cnt[IDX_W-1:0];

  always_comb begin
    out_d.status      = status;
    out_d.position    = POS_W'(pos);
    out_d.entry_count = COUNT_W'(count_d);
    if (count_d == '0) begin
      out_d.first_key = '0;
      out_d.last_key  = '0;
    end else begin
      out_d.first_key = keys_d[0];
      out_d.last_key  = keys_d[last_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.exec) begin
      keys_q <= keys_d;
      out_q  <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== hw/rtl/sorted_key_table_unit.sv =====
// Sorted key table: holds up to CAPACITY signed keys in ascending order and
// performs one insert, find or delete per item, returning one result item
// with the status, the position, the entry count and the first and last keys.
// Each item is first captured into the item register; then, in the execute
// state, every table cell compares its key and the whole row shifts in
// parallel into the result register. A new item is taken in the cycle its
// predecessor's result is taken, so the block works on one item at a time. The
// table needs no clearing after reset; entries above the count affect no result.
module sorted_key_table_unit
  import skt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  dp_cmd_t cmd;

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  skt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== hw/rtl/skt_checker.sv =====
module skt_checker
  import skt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // A pending result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item dropped or changed while stalled");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in progress");

  // Every result follows an accepted item, which passes through the execute state first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result item without an accepted input item");

  // Every result reports a count within capacity; a failed operation reports position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.entry_count <= COUNT_W'(CAPACITY)) &&
                    (out_item_o.status == STATUS_DONE || out_item_o.position == '0))
    else $error("result item fields out of range");

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (.*);
